>>> hw/rtl/btc_pkg.sv
// Shared types, constants and multiply helpers for the compensation pipeline.
`default_nettype none

package btc_pkg;

    localparam int DivW     = 31;
    localparam int NumCells = 64;
    localparam int PresFull = 1048576;
    localparam int PresScale = 3125;
    localparam int TempOff  = 128000;

    typedef enum logic [1:0] {
        CfgTempTrim = 2'd0,
        CfgPresLow  = 2'd1,
        CfgPresHigh = 2'd2,
        CfgPresLast = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] plow;
        logic [63:0] phigh;
        logic [15:0] plast;
    } t_trim;

    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tf;
        logic               qneg;
        logic               pvld;
    } t_side;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [63:0]     dq;
        logic [DivW-1:0] mb;
        t_side           side;
    } t_cell;

    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tf;
        logic [31:0]        pres;
        logic               pvld;
    } t_result;

    // Low 64 bits of a 64-bit word times an unsigned 16-bit coefficient.
    function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] b);
        logic [79:0] t;
        t = a * b;
        return t[63:0];
    endfunction

    // Low 64 bits of a 64-bit word times a signed 16-bit coefficient.
    function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic [15:0] b);
        logic [63:0] m;
        m = mul_u16(a, b);
        return b[15] ? (m - {a[47:0], 16'b0}) : m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/btc_in_if.sv
// Request channel carrying one pair of raw readings.
`default_nettype none

interface btc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/btc_out_if.sv
// Result channel carrying compensated temperature and pressure.
`default_nettype none

interface btc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;

    modport source (output valid, output temperature_centi, output fine_temperature,
                    output pressure_q24_8, output pressure_valid, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temperature,
                    input pressure_q24_8, input pressure_valid, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/btc_front.sv
// Temperature path and pressure numerator/divisor pipeline ahead of the divider.
`default_nettype none

module btc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [19:0]   i_raw_temperature,
    input  wire logic [19:0]   i_raw_pressure,
    input  wire btc_pkg::t_trim i_trim,
    output logic               o_vld,
    output btc_pkg::t_cell     o_cell
);

    localparam int DivW_W = btc_pkg::DivW;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

    assign t1 = i_trim.temp[15:0];
    assign t2 = $signed(i_trim.temp[31:16]);
    assign t3 = $signed(i_trim.temp[47:32]);
    assign p1 = i_trim.plow[15:0];
    assign p2 = $signed(i_trim.plow[31:16]);
    assign p3 = $signed(i_trim.plow[47:32]);
    assign p4 = $signed(i_trim.plow[63:48]);
    assign p5 = $signed(i_trim.phigh[15:0]);
    assign p6 = $signed(i_trim.phigh[31:16]);

    logic [10:0]        r_vld;
    logic [20:0]        r_pp [1:8];
    logic signed [31:0] r_tf [5:10];
    logic signed [31:0] r_tc [5:10];

    logic signed [31:0] r1_a, r1_b;
    logic signed [31:0] r2_m1, r2_bb;
    logic signed [31:0] r3_v1, r3_m2;
    logic signed [31:0] r4_tf;
    logic signed [33:0] r5_x;
    logic [63:0]        r6_xx, r6_xp5, r6_xp2;
    logic [63:0]        r7_xxp6, r7_xxp3, r7_w2p, r7_w1p;
    logic [63:0]        r8_w2, r8_w1a;
    logic [63:0]        r9_w1b, r9_num0;
    logic [DivW_W-1:0]  r10_w1;
    logic [63:0]        r10_num;
    btc_pkg::t_cell     r11_cell;

    logic signed [31:0] n5_t;
    logic signed [67:0] n6_xx;
    logic signed [49:0] n6_xp5, n6_xp2;
    logic signed [63:0] n8_sh;
    logic               n11_na, n11_nb;
    btc_pkg::t_cell     n11_cell;

    always_comb begin
        n5_t   = r4_tf * 32'sd5 + 32'sd128;
        n6_xx  = r5_x * r5_x;
        n6_xp5 = r5_x * p5;
        n6_xp2 = r5_x * p2;
        n8_sh  = $signed(r7_xxp3) >>> 8;
    end

    // Signs and magnitudes for the unsigned divider chain.
    always_comb begin
        n11_na             = r10_num[63];
        n11_nb             = r10_w1[DivW_W-1];
        n11_cell.rem       = '0;
        n11_cell.dq        = n11_na ? (64'd0 - r10_num) : r10_num;
        n11_cell.mb        = n11_nb ? (DivW_W'(0) - r10_w1) : r10_w1;
        n11_cell.side.tc   = r_tc[10];
        n11_cell.side.tf   = r_tf[10];
        n11_cell.side.qneg = n11_na ^ n11_nb;
        n11_cell.side.pvld = (r10_w1 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= {15'b0, i_raw_temperature[19:3]} - {15'b0, t1, 1'b0};
            r1_b     <= {16'b0, i_raw_temperature[19:4]} - {16'b0, t1};
            r_pp[1]  <= 21'(btc_pkg::PresFull) - {1'b0, i_raw_pressure};
            for (int k = 2; k <= 8; k++) begin
                r_pp[k] <= r_pp[k-1];
            end

            r2_m1    <= r1_a * t2;
            r2_bb    <= r1_b * r1_b;

            r3_v1    <= r2_m1 >>> 11;
            r3_m2    <= (r2_bb >>> 12) * t3;

            r4_tf    <= r3_v1 + (r3_m2 >>> 14);

            r_tf[5]  <= r4_tf;
            r_tc[5]  <= n5_t >>> 8;
            r5_x     <= {{2{r4_tf[31]}}, r4_tf} - 34'(btc_pkg::TempOff);
            for (int k = 6; k <= 10; k++) begin
                r_tf[k] <= r_tf[k-1];
                r_tc[k] <= r_tc[k-1];
            end

            r6_xx    <= n6_xx[63:0];
            r6_xp5   <= {{14{n6_xp5[49]}}, n6_xp5};
            r6_xp2   <= {{14{n6_xp2[49]}}, n6_xp2};

            r7_xxp6  <= btc_pkg::mul_s16(r6_xx, p6);
            r7_xxp3  <= btc_pkg::mul_s16(r6_xx, p3);
            r7_w2p   <= (r6_xp5 << 17) + ({{48{p4[15]}}, p4} << 35);
            r7_w1p   <= r6_xp2 << 12;

            r8_w2    <= r7_xxp6 + r7_w2p;
            r8_w1a   <= n8_sh + r7_w1p + 64'h0000_8000_0000_0000;

            r9_w1b   <= btc_pkg::mul_u16(r8_w1a, p1);
            r9_num0  <= {12'b0, r_pp[8], 31'b0} - r8_w2;

            r10_w1   <= r9_w1b[63:33];
            r10_num  <= btc_pkg::mul_u16(r9_num0, 16'(btc_pkg::PresScale));

            r11_cell <= n11_cell;
        end
    end

    assign o_vld  = r_vld[10];
    assign o_cell = r11_cell;

endmodule

`default_nettype wire

>>> hw/rtl/btc_div_cell.sv
// One restoring division cell: settles one quotient bit and passes the word on.
`default_nettype none

module btc_div_cell (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire btc_pkg::t_cell i_cell,
    output logic           o_vld,
    output btc_pkg::t_cell o_cell
);

    localparam int W = btc_pkg::DivW;

    logic           r_vld;
    btc_pkg::t_cell r_cell;
    logic [W:0]     n_rem2;
    logic [W:0]     n_diff;
    logic           n_ge;
    btc_pkg::t_cell n_cell;

    // The dividend shifts out of the top of dq while quotient bits fill from the bottom.
    always_comb begin
        n_rem2     = {i_cell.rem, i_cell.dq[63]};
        n_ge       = (n_rem2 >= {1'b0, i_cell.mb});
        n_diff     = n_rem2 - {1'b0, i_cell.mb};
        n_cell     = i_cell;
        n_cell.rem = n_ge ? n_diff[W-1:0] : n_rem2[W-1:0];
        n_cell.dq  = {i_cell.dq[62:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> hw/rtl/btc_back.sv
// Pressure correction terms after the division, with final saturation.
`default_nettype none

module btc_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire btc_pkg::t_cell i_cell,
    input  wire btc_pkg::t_trim i_trim,
    output logic             o_vld,
    output btc_pkg::t_result o_res
);

    logic signed [15:0] p7, p8, p9;

    assign p7 = $signed(i_trim.phigh[47:32]);
    assign p8 = $signed(i_trim.phigh[63:48]);
    assign p9 = $signed(i_trim.plast);

    logic [5:0]     r_vld;
    btc_pkg::t_side r_side [1:6];

    logic [63:0] r1_p;
    logic [63:0] r2_p, r2_ps, r2_a, r2_c2a;
    logic [63:0] r3_p, r3_ll, r3_c2;
    logic [31:0] r3_lh, r3_hl;
    logic [63:0] r4_p, r4_c1, r4_c2;
    logic [63:0] r5_s;
    logic [63:0] r6_r;

    logic signed [63:0] n2_ps, n3_c2, n4_c1, n6_sh;
    logic [63:0]        n4_c1f;

    always_comb begin
        n2_ps  = $signed(r1_p) >>> 13;
        n3_c2  = $signed(r2_c2a) >>> 19;
        n4_c1f = r3_ll + {r3_lh + r3_hl, 32'b0};
        n4_c1  = $signed(n4_c1f) >>> 25;
        n6_sh  = $signed(r5_s) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_cell.side;
            for (int k = 2; k <= 6; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r1_p   <= i_cell.side.qneg ? (64'd0 - i_cell.dq) : i_cell.dq;

            r2_p   <= r1_p;
            r2_ps  <= n2_ps;
            r2_a   <= btc_pkg::mul_s16(n2_ps, p9);
            r2_c2a <= btc_pkg::mul_s16(r1_p, p8);

            // The squared term is built from 32-bit partial products, low 64 bits only.
            r3_p   <= r2_p;
            r3_ll  <= r2_a[31:0] * r2_ps[31:0];
            r3_lh  <= 32'(r2_a[31:0] * r2_ps[63:32]);
            r3_hl  <= 32'(r2_a[63:32] * r2_ps[31:0]);
            r3_c2  <= n3_c2;

            r4_p   <= r3_p;
            r4_c1  <= n4_c1;
            r4_c2  <= r3_c2;

            r5_s   <= r4_p + r4_c1 + r4_c2;

            r6_r   <= n6_sh + {{44{p7[15]}}, p7, 4'b0};
        end
    end

    always_comb begin
        o_res.tc   = r_side[6].tc;
        o_res.tf   = r_side[6].tf;
        o_res.pvld = r_side[6].pvld;
        if (!r_side[6].pvld || r6_r[63]) begin
            o_res.pres = '0;
        end else if (|r6_r[62:32]) begin
            o_res.pres = '1;
        end else begin
            o_res.pres = r6_r[31:0];
        end
    end

    assign o_vld = r_vld[5];

endmodule

`default_nettype wire

>>> hw/rtl/baro_temp_compensation_core.sv
// Top level of the barometric temperature and pressure compensation pipeline.
// Usage: write the four trimming registers through the cfg port (index 0 temperature
// trim, 1 and 2 the packed pressure trims, 3 the last pressure trim) while no request
// is in flight; all of them reset to zero.
// Each request on i_in carries one raw temperature and one raw pressure reading and
// yields exactly one result on o_out: temperature in hundredths of a degree, the fine
// temperature, pressure in Q24.8 pascals and a flag that is low when the divisor was zero.
// Throughput is one request per cycle while i_in.ready is high. From acceptance to o_out.valid
// a request passes 11 front stages, the 64-cell divider chain (one quotient bit per cell),
// 6 correction stages and the output register.
// The pipeline moves as a whole. When the receiver stalls, the next finished result
// drops into a one-entry skid register and the pipeline freezes; i_in.ready is low only
// while that skid register is full. A synchronous reset empties the pipeline and clears
// the trimming registers; results in flight are dropped.
`default_nettype none

module baro_temp_compensation_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    btc_in_if.sink           i_in,
    btc_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    localparam int NumCells = btc_pkg::NumCells;

    btc_pkg::t_trim   r_trim;
    btc_pkg::t_result r_o, r_sk;
    logic             r_o_vld, r_sk_vld;
    logic             en;

    btc_pkg::t_cell   w_cell [0:NumCells];
    logic [NumCells:0] w_vld;
    logic             b_vld;
    btc_pkg::t_result b_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (i_cfg_we) begin
            case (btc_pkg::t_cfg_idx'(i_cfg_idx))
                btc_pkg::CfgTempTrim: r_trim.temp  <= i_cfg_data[47:0];
                btc_pkg::CfgPresLow:  r_trim.plow  <= i_cfg_data;
                btc_pkg::CfgPresHigh: r_trim.phigh <= i_cfg_data;
                btc_pkg::CfgPresLast: r_trim.plast <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_sk_vld;
    assign i_in.ready = en;

    btc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_vld             (i_in.valid),
        .i_raw_temperature (i_in.raw_temperature),
        .i_raw_pressure    (i_in.raw_pressure),
        .i_trim            (r_trim),
        .o_vld             (w_vld[0]),
        .o_cell            (w_cell[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_div
        btc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g]),
            .i_cell  (w_cell[g]),
            .o_vld   (w_vld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    btc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (w_vld[NumCells]),
        .i_cell  (w_cell[NumCells]),
        .i_trim  (r_trim),
        .o_vld   (b_vld),
        .o_res   (b_res)
    );

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (o_out.ready) begin
                r_o      <= r_sk;
                r_o_vld  <= 1'b1;
                r_sk_vld <= 1'b0;
            end
        end else if (b_vld) begin
            if (r_o_vld && !o_out.ready) begin
                r_sk     <= b_res;
                r_sk_vld <= 1'b1;
            end else begin
                r_o      <= b_res;
                r_o_vld  <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_out.valid             = r_o_vld;
    assign o_out.temperature_centi = r_o.tc;
    assign o_out.fine_temperature  = r_o.tf;
    assign o_out.pressure_q24_8    = r_o.pres;
    assign o_out.pressure_valid    = r_o.pvld;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_o_vld)
        else $error("skid entry held without a result on the output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(r_o_vld && !o_out.ready))
        else $error("skid filled while the output was free");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o.pvld) |-> (r_o.pres == '0))
        else $error("pressure not forced to zero on a zero divisor");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_vld && !o_out.ready) |=> $stable(r_o) && r_sk_vld)
        else $error("stalled result changed");

endmodule

`default_nettype wire
